>>> rtl/core/u8sd_pkg.sv
package u8sd_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int FIELD_BITS      = 16;
    localparam int CP_BITS         = 21;
    localparam int LEN_BITS        = 3;
    localparam int REM_BITS        = 2;

    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] PAY2_MASK  = 8'h1F;
    localparam logic [7:0] PAY3_MASK  = 8'h0F;
    localparam logic [7:0] PAY4_MASK  = 8'h07;
    localparam logic [7:0] CONT_MASK  = 8'h3F;
    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [LEN_BITS-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_BITS-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_BITS-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_BITS-1:0] LEN_FOUR  = 3'd4;

    localparam logic [REM_BITS-1:0] REM_NONE  = 2'd0;
    localparam logic [REM_BITS-1:0] REM_ONE   = 2'd1;
    localparam logic [REM_BITS-1:0] REM_TWO   = 2'd2;
    localparam logic [REM_BITS-1:0] REM_THREE = 2'd3;

    typedef struct packed {
        logic                  string_done;
        logic                  truncated;
        logic [FIELD_BITS-1:0] char_count;
        logic [FIELD_BITS-1:0] lead_offset;
        logic [LEN_BITS-1:0]   sequence_bytes;
        logic [CP_BITS-1:0]    code_point;
    } result_t;

endpackage

>>> rtl/core/u8sd_decode.sv
module u8sd_decode import u8sd_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    cfg_write,
    input  logic    cfg_bit,
    input  logic    in_accept,
    input  logic [7:0] data_byte,
    input  logic    end_of_string,
    output logic    push,
    output result_t result
);

    localparam int WIDE_BITS = (OFFSET_BITS > FIELD_BITS) ? OFFSET_BITS : FIELD_BITS;
    localparam logic [OFFSET_BITS-1:0] OFS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [WIDE_BITS-1:0] FIELD_MAX = WIDE_BITS'({FIELD_BITS{1'b1}});

    logic                   lb_count_reg;
    logic [CP_BITS-1:0]     acc_reg, acc_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [LEN_BITS-1:0]    len_reg, len_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] chars_reg, chars_next;
    logic [OFFSET_BITS-1:0] chars_inc, pos_inc;
    logic [WIDE_BITS-1:0]   start_wide, chars_wide;
    logic                   emit;
    logic                   line_break;

    assign chars_inc  = (chars_reg == OFS_MAX) ? chars_reg : chars_reg + 1'b1;
    assign pos_inc    = (pos_reg == OFS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign line_break = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);

    always_comb begin
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        len_next   = len_reg;
        start_next = start_reg;
        chars_next = chars_reg;
        emit       = 1'b0;
        result.code_point     = '0;
        result.sequence_bytes = len_reg;
        result.truncated      = 1'b0;
        result.string_done    = end_of_string;
        if (rem_reg == REM_NONE) begin
            start_next = pos_reg;
            if (data_byte <= ASCII_MAX) begin
                if (!line_break || lb_count_reg) begin
                    chars_next = chars_inc;
                end
                len_next = LEN_ONE;
                emit     = 1'b1;
                result.code_point     = CP_BITS'(data_byte);
                result.sequence_bytes = LEN_ONE;
            end else begin
                priority if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
                    acc_next = CP_BITS'(data_byte & PAY2_MASK);
                    rem_next = REM_ONE;
                    len_next = LEN_TWO;
                end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
                    acc_next = CP_BITS'(data_byte & PAY3_MASK);
                    rem_next = REM_TWO;
                    len_next = LEN_THREE;
                end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
                    acc_next = CP_BITS'(data_byte & PAY4_MASK);
                    rem_next = REM_THREE;
                    len_next = LEN_FOUR;
                end else begin
                    acc_next = acc_reg;
                end
                if (rem_next != REM_NONE && end_of_string) begin
                    chars_next = chars_inc;
                    emit       = 1'b1;
                    result.code_point     = acc_next;
                    result.sequence_bytes = len_next;
                    result.truncated      = 1'b1;
                end
            end
        end else begin
            acc_next = {acc_reg[CP_BITS-7:0], data_byte[5:0] & CONT_MASK[5:0]};
            rem_next = rem_reg - 1'b1;
            if (rem_next == REM_NONE || end_of_string) begin
                chars_next = chars_inc;
                emit       = 1'b1;
                result.code_point = acc_next;
                result.truncated  = (rem_next != REM_NONE);
            end
        end
        pos_next = pos_inc;
        start_wide = WIDE_BITS'(start_next);
        chars_wide = WIDE_BITS'(chars_next);
        result.lead_offset = (start_wide > FIELD_MAX) ? {FIELD_BITS{1'b1}}
                                                      : start_wide[FIELD_BITS-1:0];
        result.char_count  = (chars_wide > FIELD_MAX) ? {FIELD_BITS{1'b1}}
                                                      : chars_wide[FIELD_BITS-1:0];
    end

    assign push = in_accept && emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lb_count_reg <= 1'b0;
        end else if (cfg_write) begin
            lb_count_reg <= cfg_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            rem_reg   <= REM_NONE;
            len_reg   <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            chars_reg <= '0;
        end else if (in_accept) begin
            if (end_of_string) begin
                acc_reg   <= '0;
                rem_reg   <= REM_NONE;
                len_reg   <= '0;
                pos_reg   <= '0;
                start_reg <= '0;
                chars_reg <= '0;
            end else begin
                acc_reg   <= acc_next;
                rem_reg   <= rem_next;
                len_reg   <= len_next;
                pos_reg   <= pos_next;
                start_reg <= start_next;
                chars_reg <= chars_next;
            end
        end
    end

endmodule

>>> rtl/core/u8sd_out_buf.sv
module u8sd_out_buf import u8sd_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    can_take,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign can_take  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            main_valid_reg <= 1'b1;
            skid_valid_reg <= main_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            if (main_valid_reg) begin
                skid_reg <= push_data;
            end else begin
                main_reg <= push_data;
            end
        end
    end

endmodule

>>> rtl/core/utf8_stream_decoder_unit.sv
// A character's result is registered into the result buffer when its last byte
// (or the end-of-string byte that cuts it off) is transferred; m_tvalid presents it.
// Throughput: one byte per cycle while s_tready is high; the two-entry result
// buffer keeps s_tready high while one finished result waits on m_tready.
// Reset: synchronous, active low; clears the decoder state, the line-break
// register and the result buffer.
module utf8_stream_decoder_unit import u8sd_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,      // count_line_breaks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte[7:0]
    input  logic        s_tlast,       // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // code_point[20:0], sequence_bytes[23:21],
                                       // lead_offset[39:24], char_count[55:40]
    output logic        m_tlast,       // string_done
    output logic        m_tuser        // truncated
);

    logic    in_accept, push, can_take;
    result_t dec_result, out_result;

    assign cfg_ready = 1'b1;
    assign s_tready  = can_take;
    assign in_accept = s_tvalid && can_take;

    u8sd_decode #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_write     (cfg_valid),
        .cfg_bit       (cfg_data),
        .in_accept     (in_accept),
        .data_byte     (s_tdata),
        .end_of_string (s_tlast),
        .push          (push),
        .result        (dec_result)
    );

    u8sd_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (dec_result),
        .can_take  (can_take),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {out_result.char_count, out_result.lead_offset,
                      out_result.sequence_bytes, out_result.code_point};
    assign m_tlast = out_result.string_done;
    assign m_tuser = out_result.truncated;

endmodule
